/* rtl/core/skdmc_pkg.sv */
// Shared types and constants for the string-keyed direct-mapped cache.
// No dependencies.
`default_nettype none
package skdmc_pkg;
  localparam int HASH_W = 32;
  localparam logic [2:0] HASH_MUL = 3'd5;

  function automatic logic [5:0] coef(input logic [3:0] ph);
    logic [5:0] c;
    begin
      case (ph)
        4'd0: c = 6'd61;  4'd1: c = 6'd59;  4'd2: c = 6'd53;  4'd3: c = 6'd47;
        4'd4: c = 6'd43;  4'd5: c = 6'd41;  4'd6: c = 6'd37;  4'd7: c = 6'd31;
        4'd8: c = 6'd29;  4'd9: c = 6'd23;  4'd10: c = 6'd17; 4'd11: c = 6'd13;
        4'd12: c = 6'd11; 4'd13: c = 6'd7;  4'd14: c = 6'd3;  default: c = 6'd1;
      endcase
      return c;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/core/skdmc_hash.sv */
// Running key hash: one byte per transfer, coefficient times sign-extended byte, then x5.
// Uses skdmc_pkg.
`default_nettype none
module skdmc_hash import skdmc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              clear,
  input  wire logic [7:0]        byte_in,
  output logic      [HASH_W-1:0] hash_nxt
);
  logic [HASH_W-1:0] hash_r;
  logic [3:0]        phase_r;
  logic [HASH_W-1:0] sx;
  logic [HASH_W-1:0] t;

  assign sx = {{(HASH_W-8){byte_in[7]}}, byte_in};
  assign t = HASH_W'(sx * {26'd0, coef(phase_r)}) + hash_r;
  // x5 as shift-add
  assign hash_nxt = HASH_W'({t, 2'b00}) + t;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hash_r  <= '0;
      phase_r <= '0;
    end else if (step) begin
      hash_r  <= hash_nxt;
      phase_r <= phase_r + 4'd1;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/string_keyed_direct_mapped_cache.sv */
// Top level: key buffering, slot memories and the compare/copy sequencer.
// Uses skdmc_pkg and skdmc_hash.
//
//  channel | ports                                              | dir
//  in      | in_valid in_stall in_opcode in_key_byte in_last_byte in_entry_handle | in
//  out     | out_valid out_stall out_hit out_found_handle out_slot_index out_key_too_long | out
//
// Key bytes are taken while the input is not stalled. After the last byte the
// sequencer walks the key once through the slot byte memory for a compare or copy;
// an overlong key skips the walk. After reset a clear pass zeroes one slot valid
// mark per cycle, for all NSLOT (1024 by default) slots, with the input stalled.
// The input also stalls while the sequencer runs; a new key streams in while a
// result waits in the output register; the sequencer holds in S_OUT until it drains.
`default_nettype none
module string_keyed_direct_mapped_cache import skdmc_pkg::*; #(
  parameter int SLOT_BITS = 10,
  parameter int MAX_KEY   = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_opcode,
  input  wire logic [7:0]           in_key_byte,
  input  wire logic                 in_last_byte,
  input  wire logic [31:0]          in_entry_handle,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic [31:0]               out_found_handle,
  output logic [SLOT_BITS-1:0]      out_slot_index,
  output logic                      out_key_too_long
);
  localparam int NSLOT = 1 << SLOT_BITS;
  localparam int KB = $clog2(MAX_KEY);
  localparam logic [2:0] S_IN = 3'd0, S_RD = 3'd1, S_CMP = 3'd2, S_CPY = 3'd3,
                         S_OUT = 3'd4, S_CLR = 3'd5;

  logic [2:0] st_r;
  logic [7:0] cnt_r;
  logic       ovf_r, op_r;
  logic [31:0] hnd_r;
  logic [SLOT_BITS-1:0] slot_r;
  logic [SLOT_BITS-1:0] clr_r;
  logic [7:0] idx_r;
  logic       eq_r;
  logic [HASH_W-1:0] hash_nxt;
  logic acc, clear;

  logic [7:0]  pk_mem [MAX_KEY];
  logic [7:0]  pk_rd_r;
  logic [7:0]  kb_mem [NSLOT*(1<<KB)];
  logic [7:0]  kb_rd_r;
  // {valid, length} per slot
  logic [8:0]  len_mem [NSLOT];
  logic [8:0]  len_rd_r;
  logic [31:0] hd_mem [NSLOT];
  logic [31:0] hd_rd_r;

  assign in_stall = (st_r != S_IN);
  assign acc = in_valid && !in_stall;
  assign clear = acc && in_last_byte;

  skdmc_hash u_hash (.clk, .rst_n, .step(acc), .clear, .byte_in(in_key_byte),
                     .hash_nxt);

  logic [KB-1:0] rd_idx;
  assign rd_idx = idx_r[KB-1:0];
  logic [SLOT_BITS+KB-1:0] kaddr;
  assign kaddr = {slot_r, rd_idx};

  always_ff @(posedge clk) begin
    if (acc && cnt_r < 8'(MAX_KEY) && !ovf_r) pk_mem[cnt_r[KB-1:0]] <= in_key_byte;
    pk_rd_r <= pk_mem[rd_idx];
    if (st_r == S_CPY) kb_mem[{slot_r, KB'(idx_r - 8'd1)}] <= pk_rd_r;
    kb_rd_r <= kb_mem[kaddr];
    if (st_r == S_CLR) len_mem[clr_r] <= '0;
    else if (st_r == S_RD && op_r && !ovf_r) len_mem[slot_r] <= {1'b1, cnt_r};
    if (st_r == S_RD && op_r && !ovf_r) hd_mem[slot_r] <= hnd_r;
    len_rd_r <= len_mem[slot_r];
    hd_rd_r  <= hd_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; out_valid <= 1'b0;
      idx_r <= '0; eq_r <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + SLOT_BITS'(1);
          if (clr_r == '1) st_r <= S_IN;
        end
        S_IN: if (acc) begin
          if (cnt_r < 8'(MAX_KEY) && !ovf_r) cnt_r <= cnt_r + 8'd1;
          else ovf_r <= 1'b1;
          if (in_last_byte) begin
            if (!(cnt_r < 8'(MAX_KEY) && !ovf_r)) ovf_r <= 1'b1;
            slot_r <= hash_nxt[SLOT_BITS-1:0];
            op_r <= in_opcode; hnd_r <= in_entry_handle;
            idx_r <= '0; st_r <= S_RD;
          end
        end
        S_RD: begin
          // memories present byte idx-1 while idx is current
          idx_r <= 8'd1; eq_r <= 1'b1;
          st_r <= (ovf_r) ? S_OUT : (op_r ? S_CPY : S_CMP);
        end
        S_CMP: begin
          if (kb_rd_r != pk_rd_r) eq_r <= 1'b0;
          if (idx_r == cnt_r) st_r <= S_OUT;
          else idx_r <= idx_r + 8'd1;
        end
        S_CPY: begin
          if (idx_r == cnt_r) st_r <= S_OUT;
          else idx_r <= idx_r + 8'd1;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          out_slot_index <= slot_r;
          out_key_too_long <= ovf_r;
          out_hit <= !ovf_r && !op_r && eq_r && len_rd_r == {1'b1, cnt_r};
          out_found_handle <= (!ovf_r && !op_r && eq_r &&
                               len_rd_r == {1'b1, cnt_r}) ? hd_rd_r : 32'd0;
          cnt_r <= '0; ovf_r <= 1'b0; st_r <= S_IN;
        end
        default: st_r <= S_IN;
      endcase
    end
  end
endmodule
`default_nettype wire
